@@ rtl/tilt_angle_kalman_fusion_assert.svh @@
// Assertion macros for the tilt angle Kalman fusion block.
// Used by the top level; needs clk and rst_n in scope.
`ifndef TILT_ANGLE_KALMAN_FUSION_ASSERT_SVH
`define TILT_ANGLE_KALMAN_FUSION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TAK_ASSERT(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tak assertion failed");
`define TAK_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tak assertion failed");
`else
`define TAK_ASSERT(name, cond)
`define TAK_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ rtl/tak_pkg.sv @@
// Shared types, constants and fixed-point helpers for the tilt Kalman block.
// No dependencies.
`timescale 1ns / 1ps
package tak_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int GYRO_DIVISOR = 66;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int CNT_W = 5;
  localparam int RECIP_SH = 34;
  localparam logic [34:0] GYRO_RECIP = 35'((64'd1 << RECIP_SH) / GYRO_DIVISOR);
  localparam logic [28:0] GYRO_DIV_W = 29'(GYRO_DIVISOR);

  typedef logic signed [47:0] q_t;

  localparam q_t QMAX = 48'sh7FFF_FFFF_FFFF;
  localparam q_t QMIN = 48'sh8000_0000_0000;
  localparam q_t QONE = 48'sh0001_0000_0000;

  typedef enum logic [2:0] {
    REG_ACCEL_X_OFFSET = 3'd0,
    REG_ACCEL_Z_OFFSET = 3'd1,
    REG_GYRO_OFFSET    = 3'd2,
    REG_SAMPLE_PERIOD  = 3'd3,
    REG_ANGLE_NOISE    = 3'd4,
    REG_BIAS_NOISE     = 3'd5,
    REG_MEASURE_NOISE  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] accel_x_offset;
    logic signed [15:0] accel_z_offset;
    logic signed [15:0] gyro_offset;
    logic [31:0]        sample_period;
    logic [31:0]        angle_noise;
    logic [31:0]        bias_noise;
    logic [31:0]        measure_noise;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_XE_BIAS = 4'd0,
    ST_XE_RATE = 4'd1,
    ST_PA      = 4'd2,
    ST_PB      = 4'd3,
    ST_P11     = 4'd4,
    ST_P21     = 4'd5,
    ST_ANGLE   = 4'd6,
    ST_BIAS    = 4'd7,
    ST_CAA     = 4'd8,
    ST_CAB     = 4'd9,
    ST_CBA     = 4'd10,
    ST_CBB     = 4'd11
  } step_t;

  typedef struct packed {
    logic             load;
    logic             cordic_init;
    logic             cordic_iter;
    logic [CNT_W-1:0] iter;
    logic             mul_start;
    logic             mul_commit;
    step_t            step;
    logic             div_start;
    logic             div_commit;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } sts_t;

  function automatic q_t sat_add(input q_t a, input q_t b);
    logic [48:0] t;
    t = {a[47], a} + {b[47], b};
    if (t[48] != t[47]) return t[48] ? QMIN : QMAX;
    return t[47:0];
  endfunction

  function automatic q_t sat_sub(input q_t a, input q_t b);
    logic [48:0] t;
    t = {a[47], a} - {b[47], b};
    if (t[48] != t[47]) return t[48] ? QMIN : QMAX;
    return t[47:0];
  endfunction

  function automatic logic [47:0] mag48(input q_t v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  // atan(2^-i) in Q16.16 degrees
  function automatic logic signed [31:0] atan_val(input logic [CNT_W-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/tak_qmul.sv @@
// Sequential Q16.32 saturating multiplier: four 32x32 partial products.
// Depends on tak_pkg.
`timescale 1ns / 1ps
module tak_qmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  tak_pkg::q_t a,
  input  tak_pkg::q_t b,
  output logic        done,
  output tak_pkg::q_t p
);
  import tak_pkg::*;

  logic [47:0] ma_r, mb_r;
  logic        neg_r, busy_r, done_r;
  logic [2:0]  ph_r;
  logic [63:0] pp_r;
  logic [95:0] acc_r;
  logic [31:0] opa, opb;
  logic [6:0]  shamt;
  logic [47:0] m;

  always_comb begin
    case (ph_r)
      3'd0: begin opa = ma_r[31:0]; opb = mb_r[31:0]; end
      3'd1: begin opa = ma_r[31:0]; opb = {16'd0, mb_r[47:32]}; end
      3'd2: begin opa = {16'd0, ma_r[47:32]}; opb = mb_r[31:0]; end
      default: begin opa = {16'd0, ma_r[47:32]}; opb = {16'd0, mb_r[47:32]}; end
    endcase
    case (ph_r)
      3'd2, 3'd3: shamt = 7'd32;
      3'd4:       shamt = 7'd64;
      default:    shamt = 7'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ma_r   <= mag48(a);
        mb_r   <= mag48(b);
        neg_r  <= a[47] ^ b[47];
        acc_r  <= '0;
        ph_r   <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ph_r != 3'd4) pp_r <= opa * opb;
        if (ph_r != 3'd0) acc_r <= acc_r + (96'(pp_r) << shamt);
        if (ph_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          ph_r <= ph_r + 3'd1;
        end
      end
    end
  end

  assign m = acc_r[79:32];

  always_comb begin
    if (acc_r[95:79] != '0) p = neg_r ? QMIN : QMAX;
    else                    p = neg_r ? -q_t'(m) : q_t'(m);
  end

  assign done = done_r;

endmodule

@@ rtl/tak_qdiv.sv @@
// Two-lane restoring divider for the Kalman gains, shared divisor, one bit a cycle.
// Depends on tak_pkg.
`timescale 1ns / 1ps
module tak_qdiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  tak_pkg::q_t n1,
  input  tak_pkg::q_t n2,
  input  tak_pkg::q_t s,
  output logic        done,
  output tak_pkg::q_t q1,
  output tak_pkg::q_t q2
);
  import tak_pkg::*;

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [47:0] ms_r;
  logic        neg_r [2];
  logic        sat_r [2];
  logic [47:0] r_r   [2];
  logic [46:0] sh_r  [2];
  logic [46:0] q_r   [2];
  q_t          res   [2];
  q_t          num   [2];
  logic [47:0] mn    [2];
  logic [48:0] t     [2];

  assign num[0] = n1;
  assign num[1] = n2;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mn[l] = mag48(num[l]);
      t[l]  = {r_r[l], sh_r[l][46]};
      if (ms_r == '0)   res[l] = '0;
      else if (sat_r[l]) res[l] = neg_r[l] ? QMIN : QMAX;
      else if (neg_r[l]) res[l] = -q_t'({1'b0, q_r[l]});
      else               res[l] = q_t'({1'b0, q_r[l]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ms_r   <= mag48(s);
        cnt_r  <= '0;
        busy_r <= 1'b1;
        for (int l = 0; l < 2; l++) begin
          neg_r[l] <= num[l][47] ^ s[47];
          sat_r[l] <= {15'd0, mn[l]} >= {mag48(s), 15'd0};
          r_r[l]   <= 48'(mn[l] >> 15);
          sh_r[l]  <= {mn[l][14:0], 32'd0};
          q_r[l]   <= '0;
        end
      end else if (busy_r) begin
        for (int l = 0; l < 2; l++) begin
          sh_r[l] <= {sh_r[l][45:0], 1'b0};
          if (t[l] >= {1'b0, ms_r}) begin
            r_r[l] <= 48'(t[l] - {1'b0, ms_r});
            q_r[l] <= {q_r[l][45:0], 1'b1};
          end else begin
            r_r[l] <= t[l][47:0];
            q_r[l] <= {q_r[l][45:0], 1'b0};
          end
        end
        if (cnt_r == 6'd46) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 6'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign q1 = res[0];
  assign q2 = res[1];

endmodule

@@ rtl/tak_dp.sv @@
// Datapath: input offsets, gyro scaling, CORDIC atan2, filter state and temporaries.
// Depends on tak_pkg, tak_qmul and tak_qdiv.
`timescale 1ns / 1ps
module tak_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  tak_pkg::cfg_t      cfg,
  input  tak_pkg::cmd_t      cmd,
  output tak_pkg::sts_t      sts,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_gyro_y,
  output logic signed [31:0] out_angle_out,
  output logic signed [31:0] out_rate_out
);
  import tak_pkg::*;

  logic signed [16:0] xd_r, zd_r, gd_r;
  logic [16:0]        gmag;
  logic [51:0]        prod_r;
  logic [17:0]        q0, qc;
  logic [28:0]        qd, rem;
  logic signed [17:0] rate_r;

  logic signed [39:0] ca_r, cb_r, sa, sb, a_init;
  logic signed [31:0] ang_r;
  logic               zero_r;

  q_t angle_r, bias_r, caa_r, cab_r, cba_r, cbb_r;
  q_t xe_r, pa_r, pb_r, p11_r, p21_r, p22_r, k1_r, k2_r, e_r, omk_r;
  q_t d, w, meas, mul_a, mul_b, m, q1, q2;
  logic [33:0] rt;
  logic signed [31:0] out_angle_r, out_rate_r;

  // gyro rate: reciprocal multiply with one correction
  assign gmag = gd_r[16] ? 17'(-gd_r) : 17'(gd_r);
  assign q0   = prod_r[51:34];
  assign qd   = 29'(q0 * GYRO_DIV_W);
  assign rem  = {12'd0, gmag} - qd;
  assign qc   = (rem >= GYRO_DIV_W) ? q0 + 18'd1 : q0;

  always_ff @(posedge clk) begin
    prod_r <= {35'd0, gmag} * {17'd0, GYRO_RECIP};
    rate_r <= gd_r[16] ? -$signed(qc) : $signed(qc);
  end

  always_comb begin
    if (rate_r[17:15] != 3'b000 && rate_r[17:15] != 3'b111) w = rate_r[17] ? QMIN : QMAX;
    else w = {rate_r[15:0], 32'd0};
  end

  assign d    = {16'd0, cfg.sample_period};
  assign meas = zero_r ? '0 : {ang_r, 16'd0};

  // CORDIC
  assign a_init = {{7{zd_r[16]}}, zd_r, 16'd0};
  assign sa = ca_r >>> cmd.iter;
  assign sb = cb_r >>> cmd.iter;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xd_r <= 17'(in_accel_x) - 17'(cfg.accel_x_offset);
      zd_r <= 17'(in_accel_z) - 17'(cfg.accel_z_offset);
      gd_r <= 17'(in_gyro_y) - 17'(cfg.gyro_offset);
    end
    if (cmd.cordic_init) begin
      zero_r <= (xd_r == '0) && (zd_r == '0);
      if (zd_r[16]) begin
        ang_r <= xd_r[16] ? -32'sd11796480 : 32'sd11796480;
        ca_r  <= -a_init;
        cb_r  <= -{{7{xd_r[16]}}, xd_r, 16'd0};
      end else begin
        ang_r <= '0;
        ca_r  <= a_init;
        cb_r  <= {{7{xd_r[16]}}, xd_r, 16'd0};
      end
    end else if (cmd.cordic_iter) begin
      if (!cb_r[39]) begin
        ca_r  <= ca_r + sb;
        cb_r  <= cb_r - sa;
        ang_r <= ang_r + atan_val(cmd.iter);
      end else begin
        ca_r  <= ca_r - sb;
        cb_r  <= cb_r + sa;
        ang_r <= ang_r - atan_val(cmd.iter);
      end
    end
  end

  // multiplier operand select
  always_comb begin
    case (cmd.step)
      ST_XE_BIAS: begin mul_a = d;     mul_b = bias_r; end
      ST_XE_RATE: begin mul_a = d;     mul_b = w;      end
      ST_PA:      begin mul_a = d;     mul_b = cba_r;  end
      ST_PB:      begin mul_a = d;     mul_b = cbb_r;  end
      ST_P11:     begin mul_a = pb_r;  mul_b = d;      end
      ST_P21:     begin mul_a = cbb_r; mul_b = d;      end
      ST_ANGLE:   begin mul_a = k1_r;  mul_b = e_r;    end
      ST_BIAS:    begin mul_a = k2_r;  mul_b = e_r;    end
      ST_CAA:     begin mul_a = omk_r; mul_b = p11_r;  end
      ST_CAB:     begin mul_a = omk_r; mul_b = pb_r;   end
      ST_CBA:     begin mul_a = k2_r;  mul_b = p11_r;  end
      ST_CBB:     begin mul_a = k2_r;  mul_b = pb_r;   end
      default:    begin mul_a = '0;    mul_b = '0;     end
    endcase
  end

  tak_qmul u_qmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (sts.mul_done),
    .p     (m)
  );

  tak_qdiv u_qdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .n1    (p11_r),
    .n2    (p21_r),
    .s     (sat_add(p11_r, {16'd0, cfg.measure_noise})),
    .done  (sts.div_done),
    .q1    (q1),
    .q2    (q2)
  );

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      bias_r  <= '0;
      caa_r   <= QONE;
      cab_r   <= QONE;
      cba_r   <= QONE;
      cbb_r   <= QONE;
    end else if (cmd.mul_commit) begin
      case (cmd.step)
        ST_XE_BIAS: xe_r <= sat_sub(angle_r, m);
        ST_XE_RATE: xe_r <= sat_add(xe_r, m);
        ST_PA:      pa_r <= sat_sub(caa_r, m);
        ST_PB:      pb_r <= sat_sub(cab_r, m);
        ST_P11:     p11_r <= sat_add(sat_sub(pa_r, m), {16'd0, cfg.angle_noise});
        ST_P21: begin
          p21_r <= sat_sub(cba_r, m);
          p22_r <= sat_add(cbb_r, {16'd0, cfg.bias_noise});
        end
        ST_ANGLE:   angle_r <= sat_add(xe_r, m);
        ST_BIAS:    bias_r <= sat_add(bias_r, m);
        ST_CAA:     caa_r <= m;
        ST_CAB:     cab_r <= m;
        ST_CBA:     cba_r <= sat_sub(p21_r, m);
        ST_CBB:     cbb_r <= sat_sub(p22_r, m);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_commit) begin
      k1_r  <= q1;
      k2_r  <= q2;
      e_r   <= sat_sub(meas, xe_r);
      omk_r <= sat_sub(QONE, q1);
    end
  end

  // output word
  assign rt = {rate_r, 16'd0} - {{2{bias_r[47]}}, bias_r[47:16]};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_angle_r <= angle_r[47:16];
      if (rt[33:31] != 3'b000 && rt[33:31] != 3'b111)
        out_rate_r <= rt[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else
        out_rate_r <= rt[31:0];
    end
  end

  assign out_angle_out = out_angle_r;
  assign out_rate_out  = out_rate_r;

endmodule

@@ rtl/tak_ctrl.sv @@
// Controller: sequences CORDIC, the twelve multiplies and the gain division.
// Depends on tak_pkg.
`timescale 1ns / 1ps
module tak_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output tak_pkg::cmd_t cmd,
  input  tak_pkg::sts_t sts
);
  import tak_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_INIT   = 8'b0000_0010,
    S_CORDIC = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_MWAIT  = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_DWAIT  = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.iter  = cnt_r;
    cmd.step  = step_t'(cnt_r[3:0]);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.cordic_init = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.cordic_iter = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_ITERS - 1)) begin
          cnt_nxt   = CNT_W'(ST_XE_BIAS);
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.mul_done) begin
          cmd.mul_commit = 1'b1;
          if (cmd.step == ST_P21) begin
            state_nxt = S_DIV;
          end else if (cmd.step == ST_CBB) begin
            state_nxt = S_FIN;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.div_commit = 1'b1;
          cnt_nxt   = CNT_W'(ST_ANGLE);
          state_nxt = S_MUL;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/tilt_angle_kalman_fusion.sv @@
// Tilt angle from accelerometer and gyro by a two-state Kalman filter.
// Input channel: in_valid/in_ready with in_accel_x, in_accel_z, in_gyro_y.
// Result channel: out_valid/out_ready with out_angle_out, out_rate_out (Q16.16).
// Configuration: APB-style write/read port, one 32-bit register every 4 bytes.
// From acceptance to result: the load and CORDIC setup states,
// 24 CORDIC iterations, 12 multiplies on the shared multiplier, with
// the 47-bit gain division after the sixth of them.
// The block accepts only while idle, so it finishes one word before taking the next.
// The result sits in an output register; the next word is accepted while it
// waits. A finished word stalls the block until the register is free.
// Reset restores register defaults, zero angle and bias, every covariance entry at one.
// Depends on tak_pkg, tak_ctrl, tak_dp and the assertion macro header.
`timescale 1ns / 1ps
`include "tilt_angle_kalman_fusion_assert.svh"
module tilt_angle_kalman_fusion (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_gyro_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_angle_out,
  output logic signed [31:0] out_rate_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tak_pkg::*;

  cfg_t     cfg_r;
  cmd_t     cmd;
  sts_t     sts;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_x_offset <= 16'sd250;
      cfg_r.accel_z_offset <= 16'sd430;
      cfg_r.gyro_offset    <= 16'sd0;
      cfg_r.sample_period  <= 32'd21474836;
      cfg_r.angle_noise    <= 32'd42950;
      cfg_r.bias_noise     <= 32'd42950;
      cfg_r.measure_noise  <= 32'd21474836;
    end else if (wr) begin
      unique case (idx)
        REG_ACCEL_X_OFFSET: cfg_r.accel_x_offset <= pwdata[15:0];
        REG_ACCEL_Z_OFFSET: cfg_r.accel_z_offset <= pwdata[15:0];
        REG_GYRO_OFFSET:    cfg_r.gyro_offset    <= pwdata[15:0];
        REG_SAMPLE_PERIOD:  cfg_r.sample_period  <= pwdata;
        REG_ANGLE_NOISE:    cfg_r.angle_noise    <= pwdata;
        REG_BIAS_NOISE:     cfg_r.bias_noise     <= pwdata;
        REG_MEASURE_NOISE:  cfg_r.measure_noise  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ACCEL_X_OFFSET: prdata = 32'(cfg_r.accel_x_offset);
      REG_ACCEL_Z_OFFSET: prdata = 32'(cfg_r.accel_z_offset);
      REG_GYRO_OFFSET:    prdata = 32'(cfg_r.gyro_offset);
      REG_SAMPLE_PERIOD:  prdata = cfg_r.sample_period;
      REG_ANGLE_NOISE:    prdata = cfg_r.angle_noise;
      REG_BIAS_NOISE:     prdata = cfg_r.bias_noise;
      REG_MEASURE_NOISE:  prdata = cfg_r.measure_noise;
      default:            prdata = '0;
    endcase
  end

  tak_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tak_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd           (cmd),
    .sts           (sts),
    .in_accel_x    (in_accel_x),
    .in_accel_z    (in_accel_z),
    .in_gyro_y     (in_gyro_y),
    .out_angle_out (out_angle_out),
    .out_rate_out  (out_rate_out)
  );

  `TAK_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `TAK_ASSERT(a_units_exclusive, !(sts.mul_done && sts.div_done))
  `TAK_ASSERT(a_load_from_busy, !$rose(out_valid) || $past(!in_ready))

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for tilt_angle_kalman_fusion: drives sample words and
// APB writes, and checks every filtered angle and rate against its own
// fixed-point Kalman predictor. Depends on tak_pkg and the RTL only.
`timescale 1ns / 1ps
module tb_top;
  import tak_pkg::*;

  localparam longint LIMIT = 3000000;
  localparam longint Q48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint Q48_MIN = -64'sh0000_8000_0000_0000;
  localparam longint Q_ONE = 64'sh1_0000_0000;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
  } fused_t;

  class kalman_scoreboard;
    cfg_t cfg;
    longint ang_est, bias_est, caa, cab, cba, cbb;
    fused_t pending[$];
    int errors;

    function new();
      cfg.accel_x_offset = 16'sd250;
      cfg.accel_z_offset = 16'sd430;
      cfg.gyro_offset = 16'sd0;
      cfg.sample_period = 32'd21474836;
      cfg.angle_noise = 32'd42950;
      cfg.bias_noise = 32'd42950;
      cfg.measure_noise = 32'd21474836;
      ang_est = 0;
      bias_est = 0;
      caa = Q_ONE;
      cab = Q_ONE;
      cba = Q_ONE;
      cbb = Q_ONE;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        REG_ACCEL_X_OFFSET: cfg.accel_x_offset = v[15:0];
        REG_ACCEL_Z_OFFSET: cfg.accel_z_offset = v[15:0];
        REG_GYRO_OFFSET:    cfg.gyro_offset = v[15:0];
        REG_SAMPLE_PERIOD:  cfg.sample_period = v;
        REG_ANGLE_NOISE:    cfg.angle_noise = v;
        REG_BIAS_NOISE:     cfg.bias_noise = v;
        REG_MEASURE_NOISE:  cfg.measure_noise = v;
        default: ;
      endcase
    endfunction

    function longint sat48(longint v);
      if (v > Q48_MAX) return Q48_MAX;
      if (v < Q48_MIN) return Q48_MIN;
      return v;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned magn(longint v);
      return v < 0 ? longint'(0) - v : v;
    endfunction

    function longint fx_mul(longint a, longint b);
      bit neg;
      longint unsigned ma, mb, a1, a0, b1, b0, hi, m;
      neg = (a < 0) != (b < 0);
      ma = magn(a);
      mb = magn(b);
      a1 = ma >> 32;
      a0 = ma & 64'hFFFF_FFFF;
      b1 = mb >> 32;
      b0 = mb & 64'hFFFF_FFFF;
      hi = a1 * b1;
      if (hi >= 64'h8000) return neg ? Q48_MIN : Q48_MAX;
      m = (hi << 32) + a1 * b0 + a0 * b1 + ((a0 * b0) >> 32);
      if (m > Q48_MAX) return neg ? Q48_MIN : Q48_MAX;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function longint fx_div(longint n, longint s);
      bit neg;
      longint unsigned mn, ms, ip, r, frac, q;
      neg = (n < 0) != (s < 0);
      mn = magn(n);
      ms = magn(s);
      frac = 0;
      if (ms == 0) return 0;
      if (mn >= (ms << 15)) return neg ? Q48_MIN : Q48_MAX;
      ip = mn / ms;
      r = mn % ms;
      for (int i = 0; i < 32; i++) begin
        r = r << 1;
        frac = frac << 1;
        if (r >= ms) begin
          r = r - ms;
          frac = frac | 1;
        end
      end
      q = (ip << 32) | frac;
      if (q > Q48_MAX) return neg ? Q48_MIN : Q48_MAX;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    // vectoring CORDIC, Q16.16 degrees
    function longint tilt_deg(longint yv, longint xv);
      longint a, b, ang, na, nb;
      logic signed [31:0] tab [0:31];
      tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
              14668, 7334, 3667, 1833, 917, 458, 229, 115,
              57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      a = xv * 65536;
      b = yv * 65536;
      ang = 0;
      if (xv == 0 && yv == 0) return 0;
      if (a < 0) begin
        ang = (b >= 0) ? 180 * 65536 : -180 * 65536;
        a = -a;
        b = -b;
      end
      for (int i = 0; i < 24; i++) begin
        if (b >= 0) begin
          na = a + (b >>> i);
          nb = b - (a >>> i);
          ang += tab[i];
        end else begin
          na = a - (b >>> i);
          nb = b + (a >>> i);
          ang -= tab[i];
        end
        a = na;
        b = nb;
      end
      return ang;
    endfunction

    function void note_input(logic signed [15:0] ax, logic signed [15:0] az,
                             logic signed [15:0] gy);
      longint xd, zd, gd, rate, meas, w, d;
      longint xe, pa, pb, p11, p12, p21, p22, s, k1, k2, e, omk;
      fused_t f;
      xd = longint'(ax) - longint'(cfg.accel_x_offset);
      zd = longint'(az) - longint'(cfg.accel_z_offset);
      gd = longint'(gy) - longint'(cfg.gyro_offset);
      rate = gd / 66;
      meas = tilt_deg(xd, zd) * 65536;
      w = sat48(rate * Q_ONE);
      d = longint'({32'd0, cfg.sample_period});
      xe = sat48(sat48(ang_est - fx_mul(d, bias_est)) + fx_mul(d, w));
      pa = sat48(caa - fx_mul(d, cba));
      pb = sat48(cab - fx_mul(d, cbb));
      p11 = sat48(sat48(pa - fx_mul(pb, d)) + longint'({32'd0, cfg.angle_noise}));
      p12 = pb;
      p21 = sat48(cba - fx_mul(cbb, d));
      p22 = sat48(cbb + longint'({32'd0, cfg.bias_noise}));
      s = sat48(p11 + longint'({32'd0, cfg.measure_noise}));
      k1 = fx_div(p11, s);
      k2 = fx_div(p21, s);
      e = sat48(meas - xe);
      ang_est = sat48(xe + fx_mul(k1, e));
      bias_est = sat48(bias_est + fx_mul(k2, e));
      omk = sat48(Q_ONE - k1);
      caa = fx_mul(omk, p11);
      cab = fx_mul(omk, p12);
      cba = sat48(p21 - fx_mul(k2, p11));
      cbb = sat48(p22 - fx_mul(k2, p12));
      f.angle = 32'(ang_est >>> 16);
      f.rate = 32'(sat32(rate * 65536 - (bias_est >>> 16)));
      pending.push_back(f);
    endfunction

    function void check_result(logic signed [31:0] a, logic signed [31:0] r);
      fused_t f;
      if (pending.size() == 0) begin
        $error("unexpected word: angle_out %0d rate_out %0d", a, r);
        errors++;
        return;
      end
      f = pending.pop_front();
      if (a !== f.angle) begin
        $error("angle_out: expected %0d actual %0d", f.angle, a);
        errors++;
      end
      if (r !== f.rate) begin
        $error("rate_out: expected %0d actual %0d", f.rate, r);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] in_accel_x = 0, in_accel_z = 0, in_gyro_y = 0;
  logic out_valid;
  logic out_ready = 1;
  logic signed [31:0] out_angle_out, out_rate_out;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  logic in_rdy_s, out_vld_s;
  logic signed [31:0] angle_s, rate_s;
  bit no_gaps = 0;
  int stall_left = 0;
  longint cycles = 0;
  kalman_scoreboard sb = new();

  tilt_angle_kalman_fusion dut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    in_rdy_s = in_ready;
    out_vld_s = out_valid;
    angle_s = out_angle_out;
    rate_s = out_rate_out;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ready && out_vld_s) sb.check_result(angle_s, rate_s);
    if (stall_left > 0) begin
      out_ready <= 0;
      stall_left--;
    end else begin
      out_ready <= 1;
      if ($urandom_range(0, 9) == 0) stall_left = gap_len();
    end
  end

  task automatic send_word(logic signed [15:0] ax, logic signed [15:0] az,
                           logic signed [15:0] gy);
    int g;
    in_valid <= 1;
    in_accel_x <= ax;
    in_accel_z <= az;
    in_gyro_y <= gy;
    do @(posedge clk); while (!in_rdy_s);
    sb.note_input(ax, az, gy);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= 5'(r) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(r, v);
  endtask

  task automatic set_all(logic [15:0] xo, logic [15:0] zo, logic [15:0] go,
                         logic [31:0] dt, logic [31:0] q1, logic [31:0] q2,
                         logic [31:0] rn);
    drain();
    write_reg(REG_ACCEL_X_OFFSET, {16'd0, xo});
    write_reg(REG_ACCEL_Z_OFFSET, {16'd0, zo});
    write_reg(REG_GYRO_OFFSET, {16'd0, go});
    write_reg(REG_SAMPLE_PERIOD, dt);
    write_reg(REG_ANGLE_NOISE, q1);
    write_reg(REG_BIAS_NOISE, q2);
    write_reg(REG_MEASURE_NOISE, rn);
  endtask

  task automatic random_words(int n);
    logic signed [15:0] ax, az, gy;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          ax = 16'($urandom);
          az = 16'($urandom);
          gy = 16'($urandom);
        end
        1: begin
          ax = sb.cfg.accel_x_offset + $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
          az = sb.cfg.accel_z_offset + $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
          gy = sb.cfg.gyro_offset + $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
        end
        2: begin
          ax = $signed(16'($urandom_range(0, 1000))) - 16'sd500;
          az = 16'sd16384 + $signed(16'($urandom_range(0, 2000)));
          gy = $signed(16'($urandom_range(0, 600))) - 16'sd300;
        end
        default: begin
          ax = sb.cfg.accel_x_offset;
          az = sb.cfg.accel_z_offset;
          gy = 16'($urandom);
        end
      endcase
      send_word(ax, az, gy);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // edge cases at reset config
    send_word(16'sd250, 16'sd430, 16'sd0);
    send_word(16'sd32767, 16'sd32767, 16'sd32767);
    send_word(-16'sd32768, -16'sd32768, -16'sd32768);
    send_word(16'sd250, 16'sd1000, 16'sd65);
    send_word(16'sd250, -16'sd1000, -16'sd66);
    send_word(16'sd1000, -16'sd1000, 16'sd132);
    send_word(-16'sd1000, -16'sd1000, 16'sd0);
    send_word(16'sd1000, 16'sd430, 16'sd0);
    send_word(-16'sd1000, 16'sd430, 16'sd0);
    send_word(16'sd250, -16'sd32768, 16'sd0);

    // widest gyro span and offset extremes
    set_all(16'h8000, 16'h7FFF, 16'h7FFF, 32'd21474836, 32'd42950, 32'd42950,
            32'd21474836);
    send_word(-16'sd32768, 16'sd32767, -16'sd32768);
    send_word(16'sd32767, -16'sd32768, 16'sd32767);
    send_word(16'sd0, 16'sd0, -16'sd32768);

    // zero dt, zero noise: covariance collapses, zero innovation variance
    set_all(16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(16'sd100, 16'sd100, 16'sd500);
    send_word(16'sd100, 16'sd200, 16'sd500);
    send_word(-16'sd300, 16'sd200, -16'sd500);

    // all-ones timing and noise
    set_all(16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF);
    send_word(16'sd5000, 16'sd100, 16'sd32767);
    send_word(-16'sd5000, -16'sd100, -16'sd32768);
    random_words(60);

    set_all(16'd250, 16'd430, 16'd0, 32'd21474836, 32'd42950, 32'd42950,
            32'd21474836);
    random_words(212);
    drain();
    no_gaps = 1;
    random_words(60);
    no_gaps = 0;

    set_all(16'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom,
            $urandom);
    random_words(80);

    set_all(16'hFF00, 16'h0100, 16'h0020, 32'd85899345, 32'd4295, 32'd429,
            32'd429496729);
    random_words(120);

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/tak_pkg.sv
rtl/tak_qmul.sv
rtl/tak_qdiv.sv
rtl/tak_dp.sv
rtl/tak_ctrl.sv
rtl/tilt_angle_kalman_fusion.sv
tb/tb_top.sv
